@@ design/checkpoint_slot_table_macros.svh @@
// Assertion macros shared by the checkpoint slot table RTL
`ifndef CHECKPOINT_SLOT_TABLE_MACROS_SVH
`define CHECKPOINT_SLOT_TABLE_MACROS_SVH

// condition holds at every clock edge out of reset
`define CST_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CST_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define CST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cst_pkg.sv @@
// Types and constants of the checkpoint slot table
`default_nettype none

package cst_pkg;

  localparam int SLOTS         = 16;
  localparam int HISTORY_DEPTH = 16;
  localparam int IDX_W         = $clog2(SLOTS);
  localparam int CNT_W         = $clog2(SLOTS + 1);
  localparam int HCNT_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int ID_W          = 32;

  localparam logic [1:0] OP_CREATE     = 2'd0;
  localparam logic [1:0] OP_ROLL_ID    = 2'd1;
  localparam logic [1:0] OP_ROLL_STEPS = 2'd2;
  localparam logic [1:0] OP_PRUNE      = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  checkpoint_kind;
    logic [31:0] seek_id;
    logic [31:0] step_count;
    logic [7:0]  retain_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] result_id;
    logic [4:0]  deleted_count;
    logic [31:0] rollback_total;
    logic [4:0]  history_depth;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage

`default_nettype wire

@@ design/checkpoint_slot_table.sv @@
// Checkpoint slot table: entry memory, scan sequencer and result register
//
// One transfer in gives one result transfer out, in order. Ids and kinds live in a
// SLOTS-entry memory with one registered read port and one write port; valid
// bits and counters are flops. A create into a never-used slot, a prune that
// deletes nothing and every rejected request answer straight from idle. Rollback
// to id and create on a full table read every slot through the single read port.
// Rollback by steps first reads the current entry. Prune runs one full minimum
// scan per deleted entry. One request is in work at a time; a new one is taken
// once the previous result has left or leaves in that cycle.
// No clearing pass after reset.
`default_nettype none

`include "checkpoint_slot_table_macros.svh"

module checkpoint_slot_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire cst_pkg::in_item_t in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      cst_pkg::out_item_t out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_wr_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CUR  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  localparam logic [cst_pkg::IDX_W-1:0] LAST_IDX = cst_pkg::IDX_W'(cst_pkg::SLOTS - 1);
  localparam logic [cst_pkg::CNT_W-1:0] SLOTS_C  = cst_pkg::CNT_W'(cst_pkg::SLOTS);
  localparam logic [cst_pkg::HCNT_W-1:0] HIST_C  = cst_pkg::HCNT_W'(cst_pkg::HISTORY_DEPTH);

  cst_pkg::entry_t mem [cst_pkg::SLOTS];
  cst_pkg::entry_t mem_rdata_r;

  logic                        rd_en;
  logic [cst_pkg::IDX_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [cst_pkg::IDX_W-1:0]   wr_addr;
  cst_pkg::entry_t             wr_data;

  logic [1:0]                  state_r, state_nxt;
  logic [1:0]                  op_r, op_nxt;
  logic [1:0]                  kind_r, kind_nxt;
  logic [cst_pkg::ID_W-1:0]    target_r, target_nxt;
  logic [cst_pkg::ID_W-1:0]    steps_r, steps_nxt;
  logic [cst_pkg::CNT_W-1:0]   excess_r, excess_nxt;
  logic [cst_pkg::CNT_W-1:0]   del_r, del_nxt;
  logic [cst_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        data_vld_r, data_vld_nxt;
  logic [cst_pkg::IDX_W-1:0]   data_idx_r, data_idx_nxt;
  logic                        best_ok_r, best_ok_nxt;
  logic [cst_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [cst_pkg::ID_W-1:0]    best_id_r, best_id_nxt;
  logic [cst_pkg::SLOTS-1:0]   valid_r, valid_nxt;
  logic [cst_pkg::CNT_W-1:0]   valid_cnt_r, valid_cnt_nxt;
  logic [cst_pkg::CNT_W-1:0]   slots_used_r, slots_used_nxt;
  logic [cst_pkg::IDX_W-1:0]   cur_slot_r, cur_slot_nxt;
  logic [cst_pkg::ID_W-1:0]    next_id_r, next_id_nxt;
  logic [31:0]                 rollbacks_r, rollbacks_nxt;
  logic [cst_pkg::HCNT_W-1:0]  hist_cnt_r, hist_cnt_nxt;
  logic                        enable_r, enable_nxt;
  logic                        out_valid_r, out_valid_nxt;
  cst_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                        out_free;
  logic                        take;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    kind_nxt       = kind_r;
    target_nxt     = target_r;
    steps_nxt      = steps_r;
    excess_nxt     = excess_r;
    del_nxt        = del_r;
    cnt_nxt        = cnt_r;
    data_vld_nxt   = 1'b0;
    data_idx_nxt   = data_idx_r;
    best_ok_nxt    = best_ok_r;
    best_idx_nxt   = best_idx_r;
    best_id_nxt    = best_id_r;
    valid_nxt      = valid_r;
    valid_cnt_nxt  = valid_cnt_r;
    slots_used_nxt = slots_used_r;
    cur_slot_nxt   = cur_slot_r;
    next_id_nxt    = next_id_r;
    rollbacks_nxt  = rollbacks_r;
    hist_cnt_nxt   = hist_cnt_r;
    enable_nxt     = cfg_wr_en ? cfg_wr_data : enable_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    rd_en          = 1'b0;
    rd_addr        = cur_slot_r;
    wr_en          = 1'b0;
    wr_addr        = best_idx_r;
    wr_data.kind   = kind_r;
    wr_data.id     = next_id_r;
    take           = 1'b0;

    // default result: status OK, zero index, id and count, with current counters
    if ((state_r == S_IDLE || state_r == S_END) && out_free) begin
      out_data_nxt.status         = cst_pkg::ST_OK;
      out_data_nxt.slot_index     = '0;
      out_data_nxt.result_id      = '0;
      out_data_nxt.deleted_count  = '0;
      out_data_nxt.rollback_total = rollbacks_r;
      out_data_nxt.history_depth  = 5'(hist_cnt_r);
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt        = in_data.operation;
          kind_nxt      = in_data.checkpoint_kind;
          steps_nxt     = in_data.step_count;
          target_nxt    = in_data.seek_id;
          cnt_nxt       = '0;
          best_ok_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          case (in_data.operation)
            cst_pkg::OP_CREATE: begin
              if (!enable_r) begin
                out_data_nxt.status = cst_pkg::ST_NOT_READY;
              end else if (slots_used_r < SLOTS_C) begin
                wr_en          = 1'b1;
                wr_addr        = slots_used_r[cst_pkg::IDX_W-1:0];
                wr_data.kind   = in_data.checkpoint_kind;
                valid_nxt[slots_used_r[cst_pkg::IDX_W-1:0]] = 1'b1;
                valid_cnt_nxt  = valid_cnt_r + 1'b1;
                slots_used_nxt = slots_used_r + 1'b1;
                cur_slot_nxt   = slots_used_r[cst_pkg::IDX_W-1:0];
                next_id_nxt    = next_id_r + 1'b1;
                out_data_nxt.slot_index = 4'(slots_used_r[cst_pkg::IDX_W-1:0]);
                out_data_nxt.result_id  = next_id_r;
              end else begin
                out_valid_nxt = out_valid_r && !out_ready;
                state_nxt     = S_SCAN;
              end
            end
            cst_pkg::OP_ROLL_ID: begin
              if (!enable_r) begin
                out_data_nxt.status = cst_pkg::ST_NOT_READY;
              end else begin
                out_valid_nxt = out_valid_r && !out_ready;
                state_nxt     = S_SCAN;
              end
            end
            cst_pkg::OP_ROLL_STEPS: begin
              if (in_data.step_count == '0) begin
                out_data_nxt.status = cst_pkg::ST_INVALID;
              end else if (!valid_r[cur_slot_r] || !enable_r) begin
                out_data_nxt.status = cst_pkg::ST_NOT_READY;
              end else begin
                rd_en         = 1'b1;
                out_valid_nxt = out_valid_r && !out_ready;
                state_nxt     = S_CUR;
              end
            end
            default: begin
              if (in_data.retain_count == '0) begin
                out_data_nxt.status = cst_pkg::ST_INVALID;
              end else if (32'(valid_cnt_r) > 32'(in_data.retain_count)) begin
                excess_nxt    = valid_cnt_r - cst_pkg::CNT_W'(in_data.retain_count);
                del_nxt       = '0;
                out_valid_nxt = out_valid_r && !out_ready;
                state_nxt     = S_SCAN;
              end
            end
          endcase
        end
      end

      S_CUR: begin
        target_nxt  = (mem_rdata_r.id >= steps_r) ? (mem_rdata_r.id - steps_r) : '0;
        cnt_nxt     = '0;
        best_ok_nxt = 1'b0;
        state_nxt   = S_SCAN;
      end

      S_SCAN: begin
        if (cnt_r < SLOTS_C) begin
          rd_en        = 1'b1;
          rd_addr      = cnt_r[cst_pkg::IDX_W-1:0];
          cnt_nxt      = cnt_r + 1'b1;
          data_vld_nxt = 1'b1;
          data_idx_nxt = cnt_r[cst_pkg::IDX_W-1:0];
        end
        if (data_vld_r) begin
          if (op_r == cst_pkg::OP_CREATE) begin
            take = !best_ok_r || (mem_rdata_r.id < best_id_r);
          end else if (op_r == cst_pkg::OP_PRUNE) begin
            take = valid_r[data_idx_r] && (!best_ok_r || (mem_rdata_r.id < best_id_r));
          end else begin
            take = valid_r[data_idx_r] && !best_ok_r && (mem_rdata_r.id == target_r);
          end
          if (take) begin
            best_ok_nxt  = 1'b1;
            best_idx_nxt = data_idx_r;
            best_id_nxt  = mem_rdata_r.id;
          end
          if (data_idx_r == LAST_IDX) begin
            state_nxt = S_END;
          end
        end
      end

      default: begin
        if (out_free) begin
          case (op_r)
            cst_pkg::OP_CREATE: begin
              wr_en         = 1'b1;
              valid_nxt[best_idx_r] = 1'b1;
              valid_cnt_nxt = valid_cnt_r + (valid_r[best_idx_r] ? 1'b0 : 1'b1);
              cur_slot_nxt  = best_idx_r;
              next_id_nxt   = next_id_r + 1'b1;
              out_data_nxt.slot_index = 4'(best_idx_r);
              out_data_nxt.result_id  = next_id_r;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
            cst_pkg::OP_PRUNE: begin
              valid_nxt[best_idx_r] = 1'b0;
              valid_cnt_nxt = valid_cnt_r - 1'b1;
              del_nxt       = del_r + 1'b1;
              excess_nxt    = excess_r - 1'b1;
              if (excess_r == cst_pkg::CNT_W'(1)) begin
                out_data_nxt.deleted_count = 5'(del_r + 1'b1);
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end else begin
                cnt_nxt     = '0;
                best_ok_nxt = 1'b0;
                state_nxt   = S_SCAN;
              end
            end
            default: begin
              if (best_ok_r) begin
                if (hist_cnt_r < HIST_C) begin
                  hist_cnt_nxt = hist_cnt_r + 1'b1;
                end
                cur_slot_nxt  = best_idx_r;
                rollbacks_nxt = rollbacks_r + 1'b1;
                out_data_nxt.slot_index     = 4'(best_idx_r);
                out_data_nxt.result_id      = target_r;
                out_data_nxt.rollback_total = rollbacks_r + 1'b1;
                out_data_nxt.history_depth  =
                  5'((hist_cnt_r < HIST_C) ? hist_cnt_r + 1'b1 : hist_cnt_r);
              end else begin
                out_data_nxt.status = cst_pkg::ST_NOT_FOUND;
              end
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      data_vld_r   <= 1'b0;
      valid_r      <= '0;
      valid_cnt_r  <= '0;
      slots_used_r <= '0;
      cur_slot_r   <= '0;
      next_id_r    <= '0;
      rollbacks_r  <= '0;
      hist_cnt_r   <= '0;
      enable_r     <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      data_vld_r   <= data_vld_nxt;
      valid_r      <= valid_nxt;
      valid_cnt_r  <= valid_cnt_nxt;
      slots_used_r <= slots_used_nxt;
      cur_slot_r   <= cur_slot_nxt;
      next_id_r    <= next_id_nxt;
      rollbacks_r  <= rollbacks_nxt;
      hist_cnt_r   <= hist_cnt_nxt;
      enable_r     <= enable_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    kind_r     <= kind_nxt;
    target_r   <= target_nxt;
    steps_r    <= steps_nxt;
    excess_r   <= excess_nxt;
    del_r      <= del_nxt;
    cnt_r      <= cnt_nxt;
    data_idx_r <= data_idx_nxt;
    best_ok_r  <= best_ok_nxt;
    best_idx_r <= best_idx_nxt;
    best_id_r  <= best_id_nxt;
    out_data_r <= out_data_nxt;
  end

  `CST_ASSERT_ALWAYS(a_valid_cnt, valid_cnt_r == cst_pkg::CNT_W'($countones(valid_r)), "valid count out of step with valid bits")
  `CST_ASSERT_IMPL(a_prune_victim, (state_r == S_END) && (op_r == cst_pkg::OP_PRUNE), best_ok_r, "prune scan found no victim")
  `CST_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, (state_r != S_IDLE) || out_valid_r, "accepted transfer left no work and no result")

endmodule

`default_nettype wire
